// ----- hdl/clns_pkg.sv -----
`default_nettype none
package clns_pkg;

	localparam int MaxLineCharsDefault = 64;
	localparam int QueueDepth = 2;
	localparam int InitNibbles = 12;

	localparam logic [2:0] LineCountReset = 3'd2;
	localparam logic [6:0] CharsPerLineReset = 7'd16;

	// configuration register indexes
	localparam logic REG_LINE_COUNT = 1'b0;
	localparam logic REG_CHARS_PER_LINE = 1'b1;

	typedef enum logic [3:0] {
		FN_INIT = 4'd0,
		FN_CLEAR = 4'd1,
		FN_CURSOR_OFF = 4'd2,
		FN_CURSOR_ON = 4'd3,
		FN_DISPLAY_OFF = 4'd4,
		FN_DISPLAY_ON = 4'd5,
		FN_GOTO = 4'd6,
		FN_WRITE = 4'd7,
		FN_WRAP_START = 4'd8,
		FN_WRAP_WRITE = 4'd9
	} func_t;

	typedef enum logic [1:0] {
		JOB_INIT,
		JOB_ONE,
		JOB_TWO
	} job_kind_t;

	// one queued job: up to two bytes, or the init sequence with b0 as function set
	typedef struct packed {
		job_kind_t kind;
		logic [7:0] b0;
		logic rs0;
		logic [7:0] b1;
		logic lw;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] line_address(input logic [5:0] col,
		input logic [2:0] line, input logic [2:0] lines);
		logic [7:0] a;
		if (lines == 3'd2) begin
			a = 8'h80 + {line[1:0], 6'b0} + {2'b0, col};
		end else if (lines == 3'd4) begin
			a = 8'h80 + {line[2:1], 6'b0} + (line[0] ? 8'd20 : 8'd0) + {2'b0, col};
		end else begin
			a = 8'h80 + {2'b0, col};
		end
		return a;
	endfunction

	// bare wake-up nibbles, then function set, entry mode, display on, clear
	function automatic logic [3:0] init_nibble(input logic [3:0] idx,
		input logic [7:0] fs);
		logic [3:0] n;
		unique case (idx)
			4'd0, 4'd1, 4'd2: n = 4'h3;
			4'd3: n = 4'h2;
			4'd4: n = fs[7:4];
			4'd5: n = fs[3:0];
			4'd6: n = 4'h0;
			4'd7: n = 4'h6;
			4'd8: n = 4'h0;
			4'd9: n = 4'hC;
			4'd10: n = 4'h0;
			4'd11: n = 4'h1;
			default: n = 4'h0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/clns_front.sv -----
`default_nettype none
module clns_front import clns_pkg::*; #(
	parameter int MAX_LINE_CHARS = MaxLineCharsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [3:0] func,
	input wire logic [7:0] char_code,
	input wire logic [5:0] column,
	input wire logic [1:0] row,
	input wire logic blink,
	input wire logic [2:0] line_count,
	input wire logic [6:0] chars_per_line,
	input wire q_status_t q_stat,
	output logic q_push,
	output job_t q_job
);

	logic cursor_shown_q;
	logic cursor_blinks_q;
	logic [5:0] wrap_column_q;
	logic [2:0] wrap_line_q;

	logic accept;
	logic known;
	logic [6:0] eff_width;
	logic [6:0] next_col;
	logic wraps;
	logic [2:0] next_line;
	logic [7:0] ctrl;

	assign in_ready = !q_stat.full;
	assign accept = in_valid && in_ready;
	assign q_push = accept && known;

	always_comb begin
		if (chars_per_line == 7'd0) begin
			eff_width = 7'd1;
		end else if (chars_per_line > 7'(MAX_LINE_CHARS)) begin
			eff_width = 7'(MAX_LINE_CHARS);
		end else begin
			eff_width = chars_per_line;
		end
	end

	assign next_col = {1'b0, wrap_column_q} + 7'd1;
	assign wraps = next_col >= eff_width;
	assign next_line = wrap_line_q + 3'd1;
	assign ctrl = {6'b0, cursor_shown_q, cursor_blinks_q};

	always_comb begin
		known = 1'b1;
		q_job.kind = JOB_ONE;
		q_job.b0 = 8'h00;
		q_job.rs0 = 1'b0;
		q_job.b1 = 8'h00;
		q_job.lw = 1'b0;
		unique case (func_t'(func))
			FN_INIT: begin
				q_job.kind = JOB_INIT;
				q_job.b0 = (line_count == 3'd2) ? 8'h28 : 8'h20;
			end
			FN_CLEAR: begin
				q_job.b0 = 8'h01;
				q_job.lw = 1'b1;
			end
			FN_CURSOR_OFF: q_job.b0 = 8'h0C;
			FN_CURSOR_ON: q_job.b0 = {7'b0000111, blink};
			FN_DISPLAY_OFF: q_job.b0 = 8'h08 | ctrl;
			FN_DISPLAY_ON: q_job.b0 = 8'h0C | ctrl;
			FN_GOTO: q_job.b0 = line_address(column, {1'b0, row}, line_count);
			FN_WRITE: begin
				q_job.b0 = char_code;
				q_job.rs0 = 1'b1;
			end
			FN_WRAP_START: q_job.b0 = line_address(6'd0, 3'd0, line_count);
			FN_WRAP_WRITE: begin
				q_job.b0 = char_code;
				q_job.rs0 = 1'b1;
				if (wraps) begin
					q_job.kind = JOB_TWO;
					q_job.b1 = line_address(6'd0, next_line, line_count);
				end
			end
			default: known = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_shown_q <= 1'b0;
			cursor_blinks_q <= 1'b0;
			wrap_column_q <= '0;
			wrap_line_q <= '0;
		end else if (q_push) begin
			unique case (func_t'(func))
				FN_INIT, FN_CURSOR_OFF: begin
					cursor_shown_q <= 1'b0;
					cursor_blinks_q <= 1'b0;
				end
				FN_CURSOR_ON: begin
					cursor_shown_q <= 1'b1;
					cursor_blinks_q <= blink;
				end
				FN_WRAP_START: begin
					wrap_column_q <= '0;
					wrap_line_q <= '0;
				end
				FN_WRAP_WRITE: begin
					if (wraps) begin
						wrap_column_q <= '0;
						wrap_line_q <= next_line;
					end else begin
						wrap_column_q <= next_col[5:0];
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/clns_queue.sv -----
`default_nettype none
module clns_queue import clns_pkg::*; #(
	parameter int DEPTH = QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire job_t push_job,
	input wire logic pop,
	output job_t pop_job,
	output q_status_t stat
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign stat.full = count_q == CntW'(DEPTH);
	assign stat.empty = count_q == '0;
	assign pop_job = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/clns_back.sv -----
`default_nettype none
module clns_back import clns_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire q_status_t q_stat,
	input wire job_t q_job,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [3:0] nibble,
	output logic reg_select,
	output logic long_wait,
	output logic last
);

	job_t cur_q;
	logic busy_q;
	logic [3:0] idx_q;
	logic out_valid_q;
	logic [3:0] nibble_q;
	logic rs_q;
	logic lw_q;
	logic last_q;

	logic adv;
	logic done;
	logic [3:0] n_nib;
	logic n_rs;
	logic n_lw;
	logic n_last;
	logic [7:0] byte_sel;

	always_comb begin
		n_nib = 4'h0;
		n_rs = 1'b0;
		n_lw = 1'b0;
		n_last = 1'b0;
		byte_sel = cur_q.b0;
		unique case (cur_q.kind)
			JOB_INIT: begin
				n_nib = init_nibble(idx_q, cur_q.b0);
				n_last = idx_q == 4'(InitNibbles - 1);
				n_lw = n_last;
			end
			JOB_ONE: begin
				n_nib = idx_q[0] ? cur_q.b0[3:0] : cur_q.b0[7:4];
				n_rs = cur_q.rs0;
				n_last = idx_q[0];
				n_lw = cur_q.lw && idx_q[0];
			end
			JOB_TWO: begin
				// character first, then the address of the next line
				byte_sel = idx_q[1] ? cur_q.b1 : cur_q.b0;
				n_nib = idx_q[0] ? byte_sel[3:0] : byte_sel[7:4];
				n_rs = idx_q[1] ? 1'b0 : cur_q.rs0;
				n_last = idx_q[1:0] == 2'd3;
			end
			default: ;
		endcase
	end

	assign adv = !out_valid_q || out_ready;
	assign done = adv && busy_q && n_last;
	assign q_pop = (!busy_q || done) && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (adv && busy_q) begin
				idx_q <= idx_q + 4'd1;
			end
			if (adv) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_job;
		end
		if (adv && busy_q) begin
			nibble_q <= n_nib;
			rs_q <= n_rs;
			lw_q <= n_lw;
			last_q <= n_last;
		end
	end

	assign out_valid = out_valid_q;
	assign nibble = nibble_q;
	assign reg_select = rs_q;
	assign long_wait = lw_q;
	assign last = last_q;

endmodule
`default_nettype wire

// ----- hdl/char_lcd_nibble_command_sequencer_top.sv -----
// first nibble path: job queue, then job register, then nibble output register
// throughput: one nibble per cycle while out_ready is high; nibbles per request:
// init 12, wrapped line change 4, every other request 2, unused function codes none
// requests are taken every cycle while the two-entry job queue has room
// reset: async active low; line_count 2, chars_per_line 16, cursor and wrap state cleared
`default_nettype none
module char_lcd_nibble_command_sequencer_top import clns_pkg::*; #(
	parameter int MAX_LINE_CHARS = MaxLineCharsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [3:0] func,
	input wire logic [7:0] char_code,
	input wire logic [5:0] column,
	input wire logic [1:0] row,
	input wire logic blink,
	output logic out_valid,
	input wire logic out_ready,
	output logic [3:0] nibble,
	output logic reg_select,
	output logic long_wait,
	output logic last,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [6:0] cfg_data
);

	logic [2:0] line_count_q;
	logic [6:0] chars_per_line_q;
	q_status_t q_stat;
	job_t push_job;
	job_t pop_job;
	logic q_push;
	logic q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= LineCountReset;
			chars_per_line_q <= CharsPerLineReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE_COUNT: line_count_q <= cfg_data[2:0];
				REG_CHARS_PER_LINE: chars_per_line_q <= cfg_data;
				default: ;
			endcase
		end
	end

	clns_front #(.MAX_LINE_CHARS(MAX_LINE_CHARS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.char_code(char_code),
		.column(column),
		.row(row),
		.blink(blink),
		.line_count(line_count_q),
		.chars_per_line(chars_per_line_q),
		.q_stat(q_stat),
		.q_push(q_push),
		.q_job(push_job)
	);

	clns_queue #(.DEPTH(QueueDepth)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(push_job),
		.pop(q_pop),
		.pop_job(pop_job),
		.stat(q_stat)
	);

	clns_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_job(pop_job),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.nibble(nibble),
		.reg_select(reg_select),
		.long_wait(long_wait),
		.last(last)
	);

	a_lw_on_last_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_wait |-> last && !reg_select)
		else $error("long wait flag outside last command nibble");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("job pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("job popped from empty queue");

endmodule
`default_nettype wire
